// ===== src/spin_color_loop_product_accumulator_unit_macros.svh =====
// Assertion macros shared by the checker of the accumulator unit.
`ifndef SPIN_COLOR_LOOP_PRODUCT_ACCUMULATOR_UNIT_MACROS_SVH
`define SPIN_COLOR_LOOP_PRODUCT_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SCLPA_AST_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("accumulator unit check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SCLPA_AST_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("accumulator unit check failed");

`endif

// ===== src/sclpa_pkg.sv =====
// Package with types, constants and arithmetic helpers of the accumulator unit.
`timescale 1ns / 1ps
package sclpa_pkg;

  localparam int MATRIX_DIM   = 12;
  localparam int ELEM_BITS    = 24;
  localparam int FRAC_BITS    = ELEM_BITS - 4;
  localparam int ACC_FRAC     = 40;
  localparam int ACC_BITS     = 64;
  localparam int PROD_BITS    = 2 * ELEM_BITS;
  localparam int NUM_ELEMS    = MATRIX_DIM * MATRIX_DIM;
  localparam int NUM_ENTRIES  = NUM_ELEMS * NUM_ELEMS;
  localparam int DIM_W        = 4;
  localparam int IDX_W        = 15;
  localparam int ELEM_AW      = $clog2(NUM_ELEMS);
  localparam int ALIGN_SHIFT  = 2 * FRAC_BITS - ACC_FRAC;
  localparam int ALIGN_LSH    = (ALIGN_SHIFT < 0) ? -ALIGN_SHIFT : 0;
  localparam int ALIGN_RSH    = (ALIGN_SHIFT > 0) ? ALIGN_SHIFT : 0;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_PRELOAD = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_LAST   = DIM_W'(MATRIX_DIM - 1);
  localparam logic [IDX_W-1:0] ENTRY_LAST = IDX_W'(NUM_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]                 command;
    logic [DIM_W-1:0]           row;
    logic [DIM_W-1:0]           col;
    logic signed [ELEM_BITS-1:0] elem_real;
    logic signed [ELEM_BITS-1:0] elem_imag;
    logic [IDX_W-1:0]           entry_index;
    logic signed [ACC_BITS-1:0] preload_real;
    logic signed [ACC_BITS-1:0] preload_imag;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]           sum_index;
    logic signed [ACC_BITS-1:0] sum_real;
    logic signed [ACC_BITS-1:0] sum_imag;
  } out_word_t;

  // Bring a product with 2F fraction bits to the accumulator's fraction bits.
  // The right shift is arithmetic, which floors.
  function automatic logic signed [ACC_BITS-1:0] align_prod(
      input logic signed [PROD_BITS-1:0] p);
    logic signed [ACC_BITS-1:0] w;
    w = ACC_BITS'(p);
    return (w <<< ALIGN_LSH) >>> ALIGN_RSH;
  endfunction

  // Signed add that clamps to the accumulator range.
  function automatic logic signed [ACC_BITS-1:0] sat_add(
      input logic signed [ACC_BITS-1:0] a,
      input logic signed [ACC_BITS-1:0] b);
    logic signed [ACC_BITS:0] s;
    s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(b);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end
    return s[ACC_BITS-1:0];
  endfunction

endpackage

// ===== src/spin_color_loop_product_accumulator_unit.sv =====
// Top level of the spin-color loop product accumulator.
`timescale 1ns / 1ps
// Usage: one input channel (in_valid, in_stall, in_word) carries commands, one output
// channel (out_valid, out_stall, out_word) returns accumulator contents. A word is
// accepted on a rising edge with valid high and stall low.
// A load word writes one element of the 12x12 complex site matrix. Loading
// row 11, column 11 starts a sweep over all 20736 accumulator entries: one complex
// multiply-accumulate per cycle through a four-stage read-modify-write pipeline on the
// accumulator memory, a rate set by the single memory write port. The input stalls
// until the sweep has drained.
// A preload word writes one entry; out-of-range entries are ignored.
// A read word returns its result via the memory read and output registers; an
// out-of-range entry reads as zero. A new read waits while the previous result is
// pending or not yet taken, but loads and preloads keep flowing past a stalled result.
// After reset the block sweeps the accumulator memory to zero, one entry per cycle;
// in_stall stays high meanwhile. The site matrix is not cleared and must be fully
// loaded before the first sweep.
// While out_stall is high the result word is held unchanged in the output register.
module spin_color_loop_product_accumulator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sclpa_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sclpa_pkg::out_word_t out_word
);

  localparam int EB = sclpa_pkg::ELEM_BITS;
  localparam int AB = sclpa_pkg::ACC_BITS;
  localparam int PB = sclpa_pkg::PROD_BITS;

  // Storage: two copies of the site matrix give two reads per cycle.
  logic [2*EB-1:0] site_a [sclpa_pkg::NUM_ELEMS];
  logic [2*EB-1:0] site_b [sclpa_pkg::NUM_ELEMS];
  logic [2*AB-1:0] acc_mem [sclpa_pkg::NUM_ENTRIES];

  sclpa_pkg::state_t state_r, state_nxt;
  logic clear_en, issue_en, idle;

  logic [sclpa_pkg::IDX_W-1:0] e_r;
  logic [sclpa_pkg::DIM_W-1:0] c2_r, r1_r, c1_r, r2_r;

  logic in_acc, in_load, in_pre, in_rd, ld_ok, ld_last, idx_ok;
  logic [sclpa_pkg::ELEM_AW-1:0] ld_addr, ia, ib;

  logic [2*EB-1:0] site_a_q, site_b_q;
  logic [2*AB-1:0] acc_q;
  logic [sclpa_pkg::IDX_W-1:0] rd_addr;

  logic v1_r, v2_r, v3_r;
  logic [sclpa_pkg::IDX_W-1:0] e1_r, e2_r, e3_r;
  logic signed [PB-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [2*AB-1:0] acc1_r, acc2_r;
  logic signed [AB-1:0] re2_r, im2_r;

  logic rd_pend_r, rd_oor_r;
  logic [sclpa_pkg::IDX_W-1:0] rd_idx_r;
  logic out_valid_r;
  sclpa_pkg::out_word_t out_word_r;

  logic wr_en;
  logic [sclpa_pkg::IDX_W-1:0] wr_addr;
  logic [2*AB-1:0] wr_data;

  logic signed [EB-1:0] ar, ai, br, bi;

  // Input decode.
  assign idx_ok  = in_word.entry_index <= sclpa_pkg::ENTRY_LAST;
  assign ld_ok   = (in_word.row <= sclpa_pkg::DIM_LAST) && (in_word.col <= sclpa_pkg::DIM_LAST);
  assign ld_last = (in_word.row == sclpa_pkg::DIM_LAST) && (in_word.col == sclpa_pkg::DIM_LAST);
  assign in_stall = !idle ||
                    ((in_word.command == sclpa_pkg::CMD_READ) && (rd_pend_r || out_valid_r));
  assign in_acc  = in_valid && !in_stall;
  assign in_load = in_acc && (in_word.command == sclpa_pkg::CMD_LOAD) && ld_ok;
  assign in_pre  = in_acc && (in_word.command == sclpa_pkg::CMD_PRELOAD) && idx_ok;
  assign in_rd   = in_acc && (in_word.command == sclpa_pkg::CMD_READ);

  assign ld_addr = sclpa_pkg::ELEM_AW'(in_word.row) *
                   sclpa_pkg::ELEM_AW'(sclpa_pkg::MATRIX_DIM) +
                   sclpa_pkg::ELEM_AW'(in_word.col);
  assign ia = sclpa_pkg::ELEM_AW'(r1_r) * sclpa_pkg::ELEM_AW'(sclpa_pkg::MATRIX_DIM) +
              sclpa_pkg::ELEM_AW'(c1_r);
  assign ib = sclpa_pkg::ELEM_AW'(r2_r) * sclpa_pkg::ELEM_AW'(sclpa_pkg::MATRIX_DIM) +
              sclpa_pkg::ELEM_AW'(c2_r);

  // Sequencer: clearing pass, idle, issuing the sweep, draining the pipeline.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sclpa_pkg::ST_CLEAR: begin
        if (e_r == sclpa_pkg::ENTRY_LAST) state_nxt = sclpa_pkg::ST_IDLE;
      end
      sclpa_pkg::ST_IDLE: begin
        if (in_load && ld_last) state_nxt = sclpa_pkg::ST_SWEEP;
      end
      sclpa_pkg::ST_SWEEP: begin
        if (e_r == sclpa_pkg::ENTRY_LAST) state_nxt = sclpa_pkg::ST_DRAIN;
      end
      sclpa_pkg::ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) state_nxt = sclpa_pkg::ST_IDLE;
      end
      default: state_nxt = sclpa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clear_en = 1'b0;
    issue_en = 1'b0;
    idle     = 1'b0;
    case (state_r)
      sclpa_pkg::ST_CLEAR: clear_en = 1'b1;
      sclpa_pkg::ST_IDLE:  idle     = 1'b1;
      sclpa_pkg::ST_SWEEP: issue_en = 1'b1;
      sclpa_pkg::ST_DRAIN: idle     = 1'b0;
      default:             idle     = 1'b0;
    endcase
  end

  // Entry counter and its four digits, r2 most significant, c2 fastest.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sclpa_pkg::ST_CLEAR;
      e_r     <= '0;
      c2_r    <= '0;
      r1_r    <= '0;
      c1_r    <= '0;
      r2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (clear_en || issue_en) begin
        e_r <= (e_r == sclpa_pkg::ENTRY_LAST) ? '0 : e_r + 1'b1;
      end
      if (issue_en) begin
        if (c2_r == sclpa_pkg::DIM_LAST) begin
          c2_r <= '0;
          if (r1_r == sclpa_pkg::DIM_LAST) begin
            r1_r <= '0;
            if (c1_r == sclpa_pkg::DIM_LAST) begin
              c1_r <= '0;
              r2_r <= (r2_r == sclpa_pkg::DIM_LAST) ? '0 : r2_r + 1'b1;
            end else begin
              c1_r <= c1_r + 1'b1;
            end
          end else begin
            r1_r <= r1_r + 1'b1;
          end
        end else begin
          c2_r <= c2_r + 1'b1;
        end
      end
    end
  end

  // Site matrix memories.
  always_ff @(posedge clk) begin
    if (in_load) begin
      site_a[ld_addr] <= {in_word.elem_real, in_word.elem_imag};
      site_b[ld_addr] <= {in_word.elem_real, in_word.elem_imag};
    end
    site_a_q <= site_a[ia];
    site_b_q <= site_b[ib];
  end

  // Accumulator memory: one read port, one write port.
  assign rd_addr = issue_en ? e_r : (idx_ok ? in_word.entry_index : '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = e3_r;
    wr_data = {sclpa_pkg::sat_add(AB'(acc2_r[2*AB-1:AB]), re2_r),
               sclpa_pkg::sat_add(AB'(acc2_r[AB-1:0]), im2_r)};
    if (clear_en) begin
      wr_en   = 1'b1;
      wr_addr = e_r;
      wr_data = '0;
    end else if (v3_r) begin
      wr_en   = 1'b1;
    end else if (in_pre) begin
      wr_en   = 1'b1;
      wr_addr = in_word.entry_index;
      wr_data = {in_word.preload_real, in_word.preload_imag};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) acc_mem[wr_addr] <= wr_data;
    acc_q <= acc_mem[rd_addr];
  end

  // Multiply-accumulate pipeline.
  assign ar = site_a_q[2*EB-1:EB];
  assign ai = site_a_q[EB-1:0];
  assign br = site_b_q[2*EB-1:EB];
  assign bi = site_b_q[EB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    e1_r   <= e_r;
    e2_r   <= e1_r;
    e3_r   <= e2_r;
    p_rr_r <= PB'(ar) * PB'(br);
    p_ii_r <= PB'(ai) * PB'(bi);
    p_ri_r <= PB'(ar) * PB'(bi);
    p_ir_r <= PB'(ai) * PB'(br);
    acc1_r <= acc_q;
    acc2_r <= acc1_r;
    re2_r  <= sclpa_pkg::sat_add(sclpa_pkg::align_prod(p_rr_r),
                                 -sclpa_pkg::align_prod(p_ii_r));
    im2_r  <= sclpa_pkg::sat_add(sclpa_pkg::align_prod(p_ri_r),
                                 sclpa_pkg::align_prod(p_ir_r));
  end

  // Read path and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= in_rd;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rd) begin
      rd_idx_r <= in_word.entry_index;
      rd_oor_r <= !idx_ok;
    end
    if (rd_pend_r) begin
      out_word_r.sum_index <= rd_idx_r;
      out_word_r.sum_real  <= rd_oor_r ? '0 : acc_q[2*AB-1:AB];
      out_word_r.sum_imag  <= rd_oor_r ? '0 : acc_q[AB-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== src/sclpa_checker.sv =====
// Port-level checker of the accumulator unit and its bind statement.
`timescale 1ns / 1ps
`include "spin_color_loop_product_accumulator_unit_macros.svh"
module sclpa_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input sclpa_pkg::in_word_t  in_word,
  input logic                 out_valid,
  input logic                 out_stall,
  input sclpa_pkg::out_word_t out_word
);

  `SCLPA_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `SCLPA_AST_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word))
  `SCLPA_AST_NOW(a_read_ret,
      in_valid && !in_stall && (in_word.command == sclpa_pkg::CMD_READ),
      ##2 (out_valid && (out_word.sum_index == $past(in_word.entry_index, 2))))
  `SCLPA_AST_NOW(a_oor_zero,
      out_valid && (out_word.sum_index > sclpa_pkg::ENTRY_LAST),
      (out_word.sum_real == '0) && (out_word.sum_imag == '0))

endmodule

bind spin_color_loop_product_accumulator_unit sclpa_checker u_sclpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
